// ===== src/fpes_pkg.sv =====
// Shared types, constants and widths of the flash program/erase sequencer.
package fpes_pkg;

    // Flash geometry. The sector size is a power of two.
    localparam int unsigned SECTOR_BYTES = 65536;
    localparam int unsigned SECTOR_COUNT = 8;
    localparam int unsigned FLASH_END    = SECTOR_COUNT * SECTOR_BYTES;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 19;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 20;
    localparam int STATUS_W = 3;
    localparam int STEP_W   = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int Q7_BIT = 7;
    localparam int Q5_BIT = 5;

    localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = ADDR_W'('h555);
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = ADDR_W'('h2AA);
    localparam logic [ADDR_W-1:0] RESET_ADDR   = '0;

    localparam logic [DATA_W-1:0] CMD_UNLOCK1      = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2      = 8'h55;
    localparam logic [DATA_W-1:0] CMD_WRITE_SETUP  = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [DATA_W-1:0] CMD_READ_ARRAY   = 8'hF0;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PROGRAM = 2'd0,
        OP_ERASE   = 2'd1,
        OP_STATUS  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_ADDR_ERR  = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_BUSY      = 3'd3,
        ST_ORDER     = 3'd4,
        ST_SKIPPED   = 3'd5
    } status_t;

    // Kind of result sequence the back end has to play out.
    typedef enum logic [1:0] {
        SEQ_PROGRAM,
        SEQ_ERASE,
        SEQ_TIMEOUT,
        SEQ_REPORT
    } seq_t;

    typedef struct packed {
        seq_t                seq;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        status_t             status;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } q_push_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } q_head_t;

    // Index of the final result of each sequence.
    function automatic logic [STEP_W-1:0] seq_last_step(input seq_t seq);
        logic [STEP_W-1:0] n;
        case (seq)
            SEQ_PROGRAM: n = STEP_W'(3);
            SEQ_ERASE:   n = STEP_W'(5);
            SEQ_TIMEOUT: n = STEP_W'(1);
            default:     n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== src/fpes_if.sv =====
// Request and result channel interfaces of the flash sequencer.
interface fpes_req_if;
    import fpes_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;
    logic [LEN_W-1:0]    run_length;
    logic [DATA_W-1:0]   status_byte;

    modport source (output valid, operation, address, write_data, run_length, status_byte,
                    input ready);
    modport sink   (input valid, operation, address, write_data, run_length, status_byte,
                    output ready);
endinterface

interface fpes_res_if;
    import fpes_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [ADDR_W-1:0]   bus_address;
    logic [DATA_W-1:0]   bus_data;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, kind, bus_address, bus_data, status, last, input ready);
    modport sink   (input valid, kind, bus_address, bus_data, status, last, output ready);
endinterface

// ===== src/fpes_queue.sv =====
// Small descriptor queue between the classifying front end and the back end.
module fpes_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  fpes_pkg::q_push_t push,
    output logic             full,
    output fpes_pkg::q_head_t head,
    input  logic             pop
);
    import fpes_pkg::*;

    desc_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.desc  = entry_reg[rd_ptr_reg];

    assign do_push = push.push && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.desc;
        end
    end

    // The fill count never passes the depth and the pointers stay consistent with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/fpes_front.sv =====
// Front end: accepts requests, checks them against the sequencer state, queues work.
module fpes_front (
    input  logic              clk,
    input  logic              rst_n,
    fpes_req_if.sink          request,
    input  logic              queue_full,
    output fpes_pkg::q_push_t push
);
    import fpes_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PROGRAM,
        PH_ERASE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               exp_q7_reg, exp_q7_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;
    logic               run_failed_reg, run_failed_next;

    logic               accept;
    logic [LEN_W-1:0]   run_base;
    logic [LEN_W-1:0]   run_after;
    logic [LEN_W:0]     run_end;
    logic               run_bad;
    logic               erase_bad;
    logic               failed_eff;

    assign request.ready = !queue_full;
    assign accept        = request.valid && !queue_full;

    assign run_end   = (LEN_W + 1)'(request.address) + (LEN_W + 1)'(request.run_length);
    assign run_bad   = (request.run_length == '0)
                    || (32'(request.address) < SECTOR_BYTES)
                    || (32'(run_end) > FLASH_END);
    assign erase_bad = (32'(request.address) < SECTOR_BYTES)
                    || ((request.address & ADDR_W'(SECTOR_BYTES - 1)) != '0)
                    || (32'(request.address) >= FLASH_END);

    // A new run starts when no run is in progress.
    assign run_base   = (remaining_reg == '0) ? request.run_length : remaining_reg;
    assign run_after  = run_base - 1'b1;
    assign failed_eff = (remaining_reg == '0) ? 1'b0 : run_failed_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        exp_q7_next     = exp_q7_reg;
        remaining_next  = remaining_reg;
        run_failed_next = run_failed_reg;
        push.push        = 1'b0;
        push.desc.seq    = SEQ_REPORT;
        push.desc.addr   = request.address;
        push.desc.data   = request.write_data;
        push.desc.status = ST_OK;

        if (accept)
        begin
            case (op_t'(request.operation))
                OP_PROGRAM:
                begin
                    push.push = 1'b1;
                    if (phase_reg != PH_IDLE)
                    begin
                        push.desc.status = ST_BUSY;
                    end
                    else if (remaining_reg == '0 && run_bad)
                    begin
                        push.desc.status = ST_ADDR_ERR;
                    end
                    else
                    begin
                        remaining_next = run_after;
                        if (failed_eff)
                        begin
                            push.desc.status = ST_SKIPPED;
                            run_failed_next  = (run_after != '0);
                        end
                        else
                        begin
                            push.desc.seq   = SEQ_PROGRAM;
                            run_failed_next = 1'b0;
                            exp_q7_next     = request.write_data[Q7_BIT];
                            phase_next      = PH_PROGRAM;
                        end
                    end
                end
                OP_ERASE:
                begin
                    push.push = 1'b1;
                    if (phase_reg != PH_IDLE)
                    begin
                        push.desc.status = ST_BUSY;
                    end
                    else if (remaining_reg != '0)
                    begin
                        push.desc.status = ST_ORDER;
                    end
                    else if (erase_bad)
                    begin
                        push.desc.status = ST_ADDR_ERR;
                    end
                    else
                    begin
                        push.desc.seq = SEQ_ERASE;
                        exp_q7_next   = 1'b1;
                        phase_next    = PH_ERASE;
                    end
                end
                OP_STATUS:
                begin
                    push.push = 1'b1;
                    if (phase_reg == PH_IDLE)
                    begin
                        push.desc.status = ST_ORDER;
                    end
                    else if (request.status_byte[Q7_BIT] == exp_q7_reg)
                    begin
                        push.desc.status = ST_OK;
                        phase_next       = PH_IDLE;
                    end
                    else if (request.status_byte[Q5_BIT])
                    begin
                        push.desc.seq = SEQ_TIMEOUT;
                        if (phase_reg == PH_PROGRAM && remaining_reg != '0)
                        begin
                            run_failed_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        push.desc.status = ST_BUSY;
                    end
                end
                default:
                begin
                    push.push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            exp_q7_reg     <= 1'b0;
            remaining_reg  <= '0;
            run_failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            exp_q7_reg     <= exp_q7_next;
            remaining_reg  <= remaining_next;
            run_failed_reg <= run_failed_next;
        end
    end

    // A failed run always has bytes left to skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_failed_reg |-> (remaining_reg != '0))
        else $error("failed run flag set with no bytes left");
    // An erase is only started outside a program run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERASE) |-> (remaining_reg == '0))
        else $error("erase in progress inside a program run");

endmodule

// ===== src/fpes_back.sv =====
// Back end: plays queued sequences out as bus writes and status reports.
module fpes_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fpes_pkg::q_head_t head,
    output logic              pop,
    fpes_res_if.source        result
);
    import fpes_pkg::*;

    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                load;
    logic                is_last;

    assign out_free = !out_valid_reg || result.ready;
    assign load     = head.valid && out_free;
    assign is_last  = (step_reg == seq_last_step(head.desc.seq));
    assign pop      = load && is_last;

    // Result word for the current step of the head sequence.
    always_comb
    begin
        kind_next   = KIND_WRITE;
        addr_next   = '0;
        data_next   = '0;
        status_next = ST_OK;
        last_next   = is_last;
        case (head.desc.seq)
            SEQ_PROGRAM:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        addr_next = UNLOCK_ADDR1;
                        data_next = CMD_UNLOCK1;
                    end
                    3'd1:
                    begin
                        addr_next = UNLOCK_ADDR2;
                        data_next = CMD_UNLOCK2;
                    end
                    3'd2:
                    begin
                        addr_next = UNLOCK_ADDR1;
                        data_next = CMD_WRITE_SETUP;
                    end
                    default:
                    begin
                        addr_next = head.desc.addr;
                        data_next = head.desc.data;
                    end
                endcase
            end
            SEQ_ERASE:
            begin
                case (step_reg)
                    3'd0, 3'd3:
                    begin
                        addr_next = UNLOCK_ADDR1;
                        data_next = CMD_UNLOCK1;
                    end
                    3'd1, 3'd4:
                    begin
                        addr_next = UNLOCK_ADDR2;
                        data_next = CMD_UNLOCK2;
                    end
                    3'd2:
                    begin
                        addr_next = UNLOCK_ADDR1;
                        data_next = CMD_ERASE_SETUP;
                    end
                    default:
                    begin
                        addr_next = head.desc.addr;
                        data_next = CMD_SECTOR_ERASE;
                    end
                endcase
            end
            SEQ_TIMEOUT:
            begin
                if (step_reg == '0)
                begin
                    addr_next = RESET_ADDR;
                    data_next = CMD_READ_ARRAY;
                end
                else
                begin
                    kind_next   = KIND_REPORT;
                    status_next = ST_TIMEOUT;
                end
            end
            default:
            begin
                kind_next   = KIND_REPORT;
                status_next = head.desc.status;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = is_last ? '0 : step_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            addr_reg   <= addr_next;
            data_reg   <= data_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.bus_address = addr_reg;
    assign result.bus_data    = data_reg;
    assign result.status      = status_reg;
    assign result.last        = last_reg;

    // The step counter never runs past the end of the sequence at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> (step_reg <= seq_last_step(head.desc.seq)))
        else $error("step counter beyond end of sequence");
    // A sequence is only retired together with a result marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg))
        else $error("sequence retired without a last result");

endmodule

// ===== src/flash_program_erase_sequencer.sv =====
// Top level of the parallel NOR flash program/erase command sequencer.
// A request accepted by the front end is written into the queue, and the back end then loads
// its first result into its output register. Throughput: one result per cycle while the sink
// is ready; a request yields as many results as its sequence has (1 for a report, 2 for a
// timeout, 4 for a program byte, 6 for a sector erase), all passing through the single result
// register of the back end. Reset: rst_n clears the sequencer state, the queue and the
// result valid flag at once.
module flash_program_erase_sequencer (
    input  logic      clk,
    input  logic      rst_n,
    fpes_req_if.sink  request,
    fpes_res_if.source result
);
    import fpes_pkg::*;

    // The front end evaluates each request against the polling state and the
    // program-run bookkeeping at the moment it is accepted, so all decisions
    // are final before any bus write goes out. What it produces is a compact
    // descriptor: which sequence to play and the address, data and status it needs.
    q_push_t push;
    q_head_t head;
    logic    queue_full;
    logic    pop;

    fpes_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .queue_full (queue_full),
        .push       (push)
    );

    // The queue decouples the two halves: the front end keeps taking requests
    // while the back end is still spelling out a long unlock sequence, and
    // stalls only when the queue is full.
    fpes_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // The back end walks a step counter through the descriptor at the queue
    // head, loading one result per cycle into its output register when it is
    // free, and retires the descriptor with the result that carries the last flag.
    fpes_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule
